// File: hw/rtl/pulse_rate_detector_defines.svh
// Assertion macros used by the pulse rate detector RTL.
`ifndef PULSE_RATE_DETECTOR_DEFINES_SVH
`define PULSE_RATE_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define PRD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition never holds at a clock edge outside reset.
`define PRD_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PRD_ASSERT(lbl, clk, rst, prop, msg)
`define PRD_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// File: hw/rtl/prd_pkg.sv
// Shared widths, register indexes and reset values of the pulse rate detector.
`default_nettype none
package prd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 12;
  localparam int RATE_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int INTERVAL_W = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_THRESHOLD  = 2'd0,
    CFG_TICKS_PER_MINUTE = 2'd1,
    CFG_HIGH_RATE_LIMIT  = 2'd2,
    CFG_SAMPLE_LIMIT     = 2'd3
  } cfg_index_t;

  localparam logic signed [THR_W-1:0] THRESHOLD_RESET  = 12'sd500;
  localparam logic [RATE_W-1:0]       TPM_RESET        = 16'd6000;
  localparam logic [RATE_W-1:0]       HIGH_LIMIT_RESET = 16'd75;
  localparam logic [LIMIT_W-1:0]      SAMPLE_LIM_RESET = 15'd1100;

endpackage
`default_nettype wire

// File: hw/rtl/prd_channels.sv
// Handshake interfaces for the sample and result channels.
`default_nettype none
interface prd_in_if
  import prd_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface prd_out_if
  import prd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  sample_valid;
  logic                  peak_seen;
  logic [INTERVAL_W-1:0] beat_interval;
  logic [RATE_W-1:0]     beat_rate;
  logic [RATE_W-1:0]     mean_rate;
  logic                  mean_updated;
  logic                  mode_high;

  modport source (output valid, output sample_valid, output peak_seen,
                  output beat_interval, output beat_rate, output mean_rate,
                  output mean_updated, output mode_high, input ready);
  modport sink   (input valid, input sample_valid, input peak_seen,
                  input beat_interval, input beat_rate, input mean_rate,
                  input mean_updated, input mode_high, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/prd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module prd_div
  import prd_pkg::*;
#(
  parameter int NUM_W = 19,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;

  logic [NUM_W-1:0] trial;
  logic [CMP_W-1:0] trial_ext;
  logic [CMP_W-1:0] den_ext;
  logic             fits;

  // The remainder stays below 2^(NUM_W-1) before each shift, so its top bit can drop.
  assign trial     = {rem[NUM_W-2:0], quo[NUM_W-1]};
  assign trial_ext = CMP_W'(trial);
  assign den_ext   = CMP_W'(den);
  assign fits      = trial_ext >= den_ext;
  assign quot      = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= numer;
        den  <= denom;
      end else if (busy) begin
        rem <= fits ? NUM_W'(trial_ext - den_ext) : trial;
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pulse_rate_detector.sv
// Top level of the pulse rate detector: beat detection, interval, rate and mean rate.
//
// The block takes one signed sensor sample per word on the samples channel and
// returns exactly one result word per sample on the results channel. Both
// channels use valid/ready; a word moves when both are high at a clock edge.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
// A sample that gives no rate (invalid, no peak, first peak) goes from
// evaluation straight to the output step; a peak that measures a rate also
// runs the divider for the rate, and when that rate fills the last ring
// entry the ring is summed and the divider runs again for the mean.
// NUM_W is the width of the shared serial divider, 16 + clog2(AVG_LEN) bits;
// the divider produces one quotient bit per cycle. The sum of the rate ring
// is taken one entry per cycle.
// One sample is processed at a time; the sample channel is ready again at the
// edge where the result enters the output register, even while that result
// still waits to be taken. If the receiver stalls, the next result holds in
// its final step until the output register is free.
// Reset clears the tick counter, peak state and held values, and loads the
// register defaults; it is synchronous, with no clearing pass.
`default_nettype none
`include "pulse_rate_detector_defines.svh"
module pulse_rate_detector
  import prd_pkg::*;
#(
  parameter int AVG_LEN   = 5,
  parameter int TICK_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  prd_in_if.sink               samples,
  prd_out_if.source            results
);

  // Width of the ring index and of the rate sum.
  localparam int IDX_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  localparam int SUM_W = RATE_W + ((AVG_LEN > 1) ? $clog2(AVG_LEN) : 0);
  localparam logic [IDX_W-1:0] RING_LAST = IDX_W'(AVG_LEN - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RATE_GO,
    S_RATE_WAIT,
    S_SUM,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_OUT
  } state_t;

  // Configuration registers.
  logic signed [THR_W-1:0] pulse_threshold;
  logic [RATE_W-1:0]       ticks_per_minute;
  logic [RATE_W-1:0]       high_rate_limit;
  logic [LIMIT_W-1:0]      sample_limit;

  // Detector state.
  state_t                     state;
  logic [TICK_BITS-1:0]       tick_count;
  logic [TICK_BITS-1:0]       last_peak_tick;
  logic                       peak_valid;
  logic signed [SAMPLE_W-1:0] sample_reg;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic                       disarmed;
  logic [RATE_W-1:0]          ring [AVG_LEN];
  logic [IDX_W-1:0]           ring_fill;
  logic [IDX_W-1:0]           sum_idx;
  logic [SUM_W-1:0]           sum;
  logic [TICK_BITS-1:0]       held_interval;
  logic [RATE_W-1:0]          held_rate;
  logic [RATE_W-1:0]          held_mean;
  logic                       item_valid;
  logic                       item_peak;
  logic                       item_upd;

  // Output register.
  logic                  out_valid;
  logic                  out_sample_valid;
  logic                  out_peak_seen;
  logic [INTERVAL_W-1:0] out_interval;
  logic [RATE_W-1:0]     out_rate;
  logic [RATE_W-1:0]     out_mean;
  logic                  out_upd;
  logic                  out_high;

  // Sample classification, all on the registered sample.
  logic [SAMPLE_W-1:0]        mag;
  logic signed [SAMPLE_W-1:0] thr_ext;
  logic                       smp_ok;
  logic                       above;
  logic                       below;
  logic                       is_peak;

  // Shared divider.
  logic                 div_start;
  logic [SUM_W-1:0]     div_numer;
  logic [TICK_BITS-1:0] div_denom;
  logic                 div_busy;
  logic                 div_done;
  logic [SUM_W-1:0]     div_quot;

  assign mag     = sample_reg[SAMPLE_W-1] ? SAMPLE_W'(-sample_reg) : SAMPLE_W'(sample_reg);
  assign thr_ext = SAMPLE_W'(pulse_threshold);
  assign smp_ok  = mag < SAMPLE_W'(sample_limit);
  assign above   = sample_reg > thr_ext;
  assign below   = sample_reg < thr_ext;
  // A peak is a falling sample above the threshold while the detector is armed.
  assign is_peak = above && (prev_sample > sample_reg) && !disarmed;

  assign samples.ready = (state == S_IDLE);

  assign results.valid         = out_valid;
  assign results.sample_valid  = out_sample_valid;
  assign results.peak_seen     = out_peak_seen;
  assign results.beat_interval = out_interval;
  assign results.beat_rate     = out_rate;
  assign results.mean_rate     = out_mean;
  assign results.mean_updated  = out_upd;
  assign results.mode_high     = out_high;

  // The divider serves the rate (ticks per minute over the interval) and then
  // the mean (ring sum over AVG_LEN). A zero interval makes every quotient bit
  // one, which is the saturated rate.
  assign div_start = (state == S_RATE_GO) || (state == S_MEAN_GO);
  assign div_numer = (state == S_MEAN_GO) ? sum : SUM_W'(ticks_per_minute);
  assign div_denom = (state == S_MEAN_GO) ? TICK_BITS'(AVG_LEN) : held_interval;

  prd_div #(
    .NUM_W (SUM_W),
    .DEN_W (TICK_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_threshold  <= THRESHOLD_RESET;
      ticks_per_minute <= TPM_RESET;
      high_rate_limit  <= HIGH_LIMIT_RESET;
      sample_limit     <= SAMPLE_LIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PULSE_THRESHOLD:  pulse_threshold  <= cfg_data[THR_W-1:0];
        CFG_TICKS_PER_MINUTE: ticks_per_minute <= cfg_data[RATE_W-1:0];
        CFG_HIGH_RATE_LIMIT:  high_rate_limit  <= cfg_data[RATE_W-1:0];
        CFG_SAMPLE_LIMIT:     sample_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tick_count     <= '0;
      last_peak_tick <= '0;
      peak_valid     <= 1'b0;
      prev_sample    <= '0;
      disarmed       <= 1'b0;
      ring_fill      <= '0;
      held_interval  <= '0;
      held_rate      <= '0;
      held_mean      <= '0;
      out_valid      <= 1'b0;
    end else begin
      // In S_OUT the output register is reloaded instead, so it is not cleared there.
      if (results.valid && results.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          // The tick counter advances on every sample, valid or not.
          if (samples.valid) begin
            sample_reg <= samples.sample;
            tick_count <= tick_count + TICK_BITS'(1);
            state      <= S_EVAL;
          end
        end
        S_EVAL: begin
          item_valid <= smp_ok;
          item_peak  <= smp_ok && is_peak;
          item_upd   <= 1'b0;
          sum        <= '0;
          sum_idx    <= '0;
          state      <= S_OUT;
          if (smp_ok) begin
            prev_sample <= sample_reg;
            if (below) begin
              disarmed <= 1'b0;
            end
            if (is_peak) begin
              disarmed       <= 1'b1;
              last_peak_tick <= tick_count;
              peak_valid     <= 1'b1;
              // The first peak only records its tick.
              if (peak_valid) begin
                held_interval <= tick_count - last_peak_tick;
                state         <= S_RATE_GO;
              end
            end
          end
        end
        S_RATE_GO: begin
          state <= S_RATE_WAIT;
        end
        S_RATE_WAIT: begin
          if (div_done) begin
            held_rate       <= div_quot[RATE_W-1:0];
            ring[ring_fill] <= div_quot[RATE_W-1:0];
            if (ring_fill == RING_LAST) begin
              ring_fill <= '0;
              state     <= S_SUM;
            end else begin
              ring_fill <= ring_fill + IDX_W'(1);
              state     <= S_OUT;
            end
          end
        end
        S_SUM: begin
          sum <= sum + SUM_W'(ring[sum_idx]);
          if (sum_idx == RING_LAST) begin
            state <= S_MEAN_GO;
          end else begin
            sum_idx <= sum_idx + IDX_W'(1);
          end
        end
        S_MEAN_GO: begin
          state <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            held_mean <= div_quot[RATE_W-1:0];
            item_upd  <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || results.ready) begin
            out_valid        <= 1'b1;
            out_sample_valid <= item_valid;
            out_peak_seen    <= item_peak;
            out_interval     <= INTERVAL_W'(held_interval);
            out_rate         <= held_rate;
            out_mean         <= held_mean;
            out_upd          <= item_upd;
            out_high         <= held_rate > high_rate_limit;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PRD_ASSERT(a_tick_advance, clk, rst, (samples.valid && samples.ready) |=> (tick_count == $past(tick_count) + TICK_BITS'(1)), "tick counter did not advance on a sample")
  `PRD_NEVER(a_div_overlap, clk, rst, div_start && div_busy, "divider started while busy")
  `PRD_NEVER(a_ring_range, clk, rst, ring_fill > RING_LAST, "ring fill out of range")
  `PRD_ASSERT(a_peak_valid, clk, rst, (results.valid && results.peak_seen) |-> results.sample_valid, "peak reported on an invalid sample")
  `PRD_ASSERT(a_mean_peak, clk, rst, (results.valid && results.mean_updated) |-> results.peak_seen, "mean refreshed without a peak")

endmodule
`default_nettype wire

// File: tb/sv/pulse_rate_detector_test.sv
// Self-checking testbench for the pulse rate detector: directed and random sample streams.
module pulse_rate_detector_test;
  import prd_pkg::*;

  // Length of the rate ring inside the block; the instance keeps its default.
  localparam int RING_LEN = 5;
  // Percentage of cycles in which either side idles while idling is enabled.
  localparam int IDLE_PCT = 36;
  // Cycles with no word moving on either channel before the run is abandoned.
  // It leaves a wide margin over the slowest result and the random gaps and stalls.
  localparam int WATCHDOG_LIMIT = 3000;
  // Quiet cycles after the last result, longer than the slowest result takes.
  localparam int SETTLE_CYCLES = 60;
  localparam int OPENING_ROWS = 25;
  localparam int MAX_PRINTED = 50;

  // One result word, field by field.
  typedef struct packed {
    logic                  sample_valid;
    logic                  peak_seen;
    logic [INTERVAL_W-1:0] beat_interval;
    logic [RATE_W-1:0]     beat_rate;
    logic [RATE_W-1:0]     mean_rate;
    logic                  mean_updated;
    logic                  mode_high;
  } beat_report_t;

  // A row of the opening sequence. Where known is set, the result is simple
  // enough to spell out: the rate, interval and mean fields are all zero and
  // only the valid and peak flags are given.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    bit                         known;
    logic                       valid_bit;
    logic                       peak_bit;
  } opening_row_t;

  // One full register setting.
  typedef struct {
    logic signed [THR_W-1:0] threshold;
    logic [RATE_W-1:0]       tpm;
    logic [RATE_W-1:0]       high_limit;
    logic [LIMIT_W-1:0]      limit;
  } detector_setup_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  prd_in_if  samples_ch ();
  prd_out_if results_ch ();

  pulse_rate_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_ch),
    .results   (results_ch)
  );

  // The opening sequence runs with the reset settings: threshold 500 and a
  // sample bound of 1100. It starts with four samples that are all out of
  // bounds, the extremes of the sample field and the values right on the bound,
  // then a sample one inside the bound, then the first peak, which only records
  // its tick. Then come beats that each produce a rate, with a sample right on
  // the threshold, a negative sample right inside the bound and an out-of-bounds
  // sample in the middle of a beat. The fifth rate refreshes the mean.
  opening_row_t opening_rows [OPENING_ROWS] = '{
    '{16'sh7FFF,    1'b1, 1'b0, 1'b0},
    '{16'sh8000,    1'b1, 1'b0, 1'b0},
    '{16'sd1100,    1'b1, 1'b0, 1'b0},
    '{-16'sd1100,   1'b1, 1'b0, 1'b0},
    '{16'sd1099,    1'b1, 1'b1, 1'b0},
    '{16'sd600,     1'b1, 1'b1, 1'b1},
    '{16'sd800,     1'b0, 1'b0, 1'b0},
    '{16'sd500,     1'b0, 1'b0, 1'b0},
    '{-16'sd1099,   1'b0, 1'b0, 1'b0},
    '{16'sd900,     1'b0, 1'b0, 1'b0},
    '{16'sd2000,    1'b0, 1'b0, 1'b0},
    '{16'sd600,     1'b0, 1'b0, 1'b0},
    '{16'sd0,       1'b0, 1'b0, 1'b0},
    '{16'sd1000,    1'b0, 1'b0, 1'b0},
    '{16'sd501,     1'b0, 1'b0, 1'b0},
    '{-16'sd500,    1'b0, 1'b0, 1'b0},
    '{16'sd700,     1'b0, 1'b0, 1'b0},
    '{16'sd650,     1'b0, 1'b0, 1'b0},
    '{16'sd100,     1'b0, 1'b0, 1'b0},
    '{16'sd1050,    1'b0, 1'b0, 1'b0},
    '{16'sd520,     1'b0, 1'b0, 1'b0},
    '{16'sd499,     1'b0, 1'b0, 1'b0},
    '{16'sd800,     1'b0, 1'b0, 1'b0},
    '{16'sd700,     1'b0, 1'b0, 1'b0},
    '{16'sd0,       1'b0, 1'b0, 1'b0}
  };

  // Register copies held by the predictor.
  logic signed [THR_W-1:0] thr_reg;
  logic [RATE_W-1:0]       tpm_reg;
  logic [RATE_W-1:0]       hrl_reg;
  logic [LIMIT_W-1:0]      lim_reg;

  // Detector state held by the predictor.
  logic [INTERVAL_W-1:0]      tick_now;
  logic [INTERVAL_W-1:0]      last_peak_at;
  bit                         peak_known;
  logic signed [SAMPLE_W-1:0] last_valid_sample;
  bit                         detector_disarmed;
  logic [RATE_W-1:0]          rate_hist [RING_LEN];
  int unsigned                hist_fill;
  logic [RATE_W-1:0]          rate_now;
  logic [INTERVAL_W-1:0]      interval_now;
  logic [RATE_W-1:0]          mean_now;

  // Results owed by the block, oldest first.
  beat_report_t pending_reports [$];

  bit          gaps_enabled;
  int unsigned mismatch_count;
  int unsigned samples_sent;
  int unsigned reports_checked;
  int unsigned peaks_checked;
  int unsigned means_checked;
  int unsigned invalid_checked;
  int unsigned settings_used;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Puts the predictor in its reset state, registers at their defaults.
  function automatic void clear_predictor();
    thr_reg = THRESHOLD_RESET;
    tpm_reg = TPM_RESET;
    hrl_reg = HIGH_LIMIT_RESET;
    lim_reg = SAMPLE_LIM_RESET;
    tick_now = '0;
    last_peak_at = '0;
    peak_known = 1'b0;
    last_valid_sample = '0;
    detector_disarmed = 1'b0;
    foreach (rate_hist[i]) rate_hist[i] = '0;
    hist_fill = 0;
    rate_now = '0;
    interval_now = '0;
    mean_now = '0;
  endfunction

  // Advances the predicted detector by one sample and returns the result word
  // that the sample should produce.
  function automatic beat_report_t advance_beat(logic signed [SAMPLE_W-1:0] s);
    int                    sv;
    int                    mag;
    bit                    in_bounds;
    beat_report_t          r;
    logic [INTERVAL_W-1:0] gap;
    logic [31:0]           quot;
    logic [31:0]           total;
    sv = s;
    mag = (sv < 0) ? -sv : sv;
    in_bounds = mag < int'(lim_reg);
    r = '0;
    // The tick counter runs on every sample, in bounds or not.
    tick_now = tick_now + 1'b1;
    if (in_bounds) begin
      if (sv > int'(thr_reg) && int'(last_valid_sample) > sv && !detector_disarmed) begin
        r.peak_seen = 1'b1;
        detector_disarmed = 1'b1;
        // The first peak after reset only marks its tick.
        if (peak_known) begin
          gap = tick_now - last_peak_at;
          interval_now = gap;
          // A zero interval can only come from a full wrap of the counter;
          // the divider saturates then.
          quot = (gap == '0) ? 32'h0000_FFFF : {16'd0, tpm_reg} / gap;
          rate_now = quot[RATE_W-1:0];
          if (hist_fill >= RING_LEN) hist_fill = 0;
          rate_hist[hist_fill] = rate_now;
          hist_fill++;
          if (hist_fill >= RING_LEN) begin
            total = '0;
            for (int i = 0; i < RING_LEN; i++) total += 32'(rate_hist[i]);
            total = total / RING_LEN;
            mean_now = total[RATE_W-1:0];
            hist_fill = 0;
            r.mean_updated = 1'b1;
          end
        end
        last_peak_at = tick_now;
        peak_known = 1'b1;
      end
      last_valid_sample = s;
      if (sv < int'(thr_reg)) detector_disarmed = 1'b0;
    end
    r.sample_valid = in_bounds;
    r.beat_interval = interval_now;
    r.beat_rate = rate_now;
    r.mean_rate = mean_now;
    r.mode_high = rate_now > hrl_reg;
    return r;
  endfunction

  function automatic int pick(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic flag_mismatch(string detail);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("MISMATCH at result word %0d: %s", reports_checked, detail);
  endtask

  task automatic check_report(beat_report_t got, beat_report_t want);
    if (got.sample_valid !== want.sample_valid)
      flag_mismatch($sformatf("sample_valid %0b, predicted %0b",
                              got.sample_valid, want.sample_valid));
    if (got.peak_seen !== want.peak_seen)
      flag_mismatch($sformatf("peak_seen %0b, predicted %0b",
                              got.peak_seen, want.peak_seen));
    if (got.beat_interval !== want.beat_interval)
      flag_mismatch($sformatf("beat_interval %0d, predicted %0d",
                              got.beat_interval, want.beat_interval));
    if (got.beat_rate !== want.beat_rate)
      flag_mismatch($sformatf("beat_rate %0d, predicted %0d",
                              got.beat_rate, want.beat_rate));
    if (got.mean_rate !== want.mean_rate)
      flag_mismatch($sformatf("mean_rate %0d, predicted %0d",
                              got.mean_rate, want.mean_rate));
    if (got.mean_updated !== want.mean_updated)
      flag_mismatch($sformatf("mean_updated %0b, predicted %0b",
                              got.mean_updated, want.mean_updated));
    if (got.mode_high !== want.mode_high)
      flag_mismatch($sformatf("mode_high %0b, predicted %0b",
                              got.mode_high, want.mode_high));
  endtask

  // Offers one sample word and returns at the edge where it is taken. The
  // task is always entered right after a rising edge. When no idle cycles are
  // drawn, valid simply stays high and only the payload changes, so valid never
  // gets two assignments in one step. The expectation is queued at acceptance,
  // with the register copies as they stand then.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, bit use_known,
                             beat_report_t known_want);
    int unsigned  idle_cycles;
    beat_report_t want;
    idle_cycles = 0;
    while (gaps_enabled && $urandom_range(0, 99) < IDLE_PCT) idle_cycles++;
    if (idle_cycles != 0) begin
      samples_ch.valid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= s;
    do @(posedge clk); while (!(samples_ch.valid && samples_ch.ready));
    want = advance_beat(s);
    if (use_known) want = known_want;
    pending_reports.push_back(want);
    samples_sent++;
  endtask

  // Stops offering samples and waits until every owed result word has been
  // taken. Every sample yields a result, so the block is idle after that.
  task automatic wait_results_settled();
    samples_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // Drives one register write. The write enable is left high so that a run of
  // writes keeps it asserted; the caller lowers it after the last one.
  task automatic put_register(cfg_index_t idx, logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_PULSE_THRESHOLD:  thr_reg = data[THR_W-1:0];
      CFG_TICKS_PER_MINUTE: tpm_reg = data;
      CFG_HIGH_RATE_LIMIT:  hrl_reg = data;
      CFG_SAMPLE_LIMIT:     lim_reg = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Random stream for the current setting. Most of it is made of beats shaped
  // like a real pulse: a dip below the threshold that re-arms the detector, a
  // rise to a crest above the threshold and a fall that is still above it,
  // which is where the peak is detected. Some beats have no fall above the
  // threshold and miss their peak. About one draw in five is a single word of
  // raw noise over the whole 16-bit range, which also covers out-of-bounds
  // samples. Now and then the stream pauses until every result has come back.
  task automatic random_samples(int unsigned count);
    int unsigned sent;
    int          thr_i;
    int          hi;
    int          lo;
    int          dip_floor;
    int          crest;
    sent = 0;
    while (sent < count) begin
      thr_i = thr_reg;
      hi = int'(lim_reg) - 1;
      lo = -hi;
      dip_floor = (lo > thr_i - 400) ? lo : thr_i - 400;
      if ($urandom_range(0, 99) < 3) wait_results_settled();
      if ($urandom_range(0, 99) < 20) begin
        send_sample(16'($urandom), 1'b0, '0);
        sent++;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_sample(16'(pick(dip_floor, thr_i - 1)), 1'b0, '0);
          sent++;
        end
        crest = pick(thr_i + 2, (hi < thr_i + 800) ? hi : thr_i + 800);
        repeat ($urandom_range(0, 2)) begin
          send_sample(16'(pick(thr_i + 1, crest - 1)), 1'b0, '0);
          sent++;
        end
        send_sample(16'(crest), 1'b0, '0);
        sent++;
        if ($urandom_range(0, 99) < 85) begin
          send_sample(16'(pick(thr_i + 1, crest - 1)), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // Waits for the block to go idle, writes all four registers, then runs a
  // random stream. A steady phase turns idling off on both channels.
  task automatic run_phase(detector_setup_t setup, int unsigned count, bit steady);
    wait_results_settled();
    put_register(CFG_PULSE_THRESHOLD,
                 {{(CFG_W - THR_W){setup.threshold[THR_W-1]}}, setup.threshold});
    put_register(CFG_TICKS_PER_MINUTE, setup.tpm);
    put_register(CFG_HIGH_RATE_LIMIT, setup.high_limit);
    put_register(CFG_SAMPLE_LIMIT, {{(CFG_W - LIMIT_W){1'b0}}, setup.limit});
    cfg_wr_en <= 1'b0;
    settings_used++;
    gaps_enabled = !steady;
    random_samples(count);
  endtask

  // Result side: takes words whenever ready is high and checks each against
  // the oldest expectation. Ready is drawn at random each cycle while idling
  // is enabled and held high otherwise. The handshake is judged on the values
  // from before the edge, so it does not matter when this process runs.
  initial begin
    beat_report_t got;
    beat_report_t want;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid && results_ch.ready) begin
        got = '0;
        got.sample_valid  = results_ch.sample_valid;
        got.peak_seen     = results_ch.peak_seen;
        got.beat_interval = results_ch.beat_interval;
        got.beat_rate     = results_ch.beat_rate;
        got.mean_rate     = results_ch.mean_rate;
        got.mean_updated  = results_ch.mean_updated;
        got.mode_high     = results_ch.mode_high;
        if (pending_reports.size() == 0) begin
          flag_mismatch("result word arrived with no sample waiting for it");
        end else begin
          want = pending_reports.pop_front();
          check_report(got, want);
        end
        reports_checked++;
        if (got.peak_seen === 1'b1) peaks_checked++;
        if (got.mean_updated === 1'b1) means_checked++;
        if (got.sample_valid === 1'b0) invalid_checked++;
      end
      results_ch.ready <= !gaps_enabled || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: counts edges at which no word moves on either channel.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (samples_ch.valid && samples_ch.ready) ||
          (results_ch.valid && results_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no word moved for %0d cycles, %0d results still owed.",
             WATCHDOG_LIMIT, pending_reports.size());
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence: reset, the opening rows, then random streams under a
  // series of settings that includes both ends of the numerator and rate limit.
  initial begin
    detector_setup_t setup;
    beat_report_t    fixed_want;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_PULSE_THRESHOLD;
    cfg_data <= '0;
    samples_ch.valid <= 1'b0;
    samples_ch.sample <= '0;
    gaps_enabled = 1'b1;
    mismatch_count = 0;
    samples_sent = 0;
    reports_checked = 0;
    peaks_checked = 0;
    means_checked = 0;
    invalid_checked = 0;
    settings_used = 1;
    clear_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < OPENING_ROWS; i++) begin
      fixed_want = '0;
      fixed_want.sample_valid = opening_rows[i].valid_bit;
      fixed_want.peak_seen = opening_rows[i].peak_bit;
      send_sample(opening_rows[i].sample, opening_rows[i].known, fixed_want);
    end
    random_samples(70);

    // Lowest threshold, largest numerator, zero rate limit and the widest
    // sample bound; idling is off on both sides for this whole stretch.
    setup = '{-12'sd1100, 16'hFFFF, 16'd0, 15'h7FFF};
    run_phase(setup, 70, 1'b1);
    // Highest threshold, numerator of one and the top rate limit: every rate
    // rounds to zero and high mode never shows.
    setup = '{12'sd1100, 16'd1, 16'hFFFF, 15'd1500};
    run_phase(setup, 50, 1'b0);
    // A zero numerator gives a zero rate for every nonzero interval.
    setup = '{12'sd0, 16'd0, 16'd1, 15'd4000};
    run_phase(setup, 50, 1'b0);
    // A sample bound of one: only a sample of zero is in bounds.
    setup = '{-12'sd1, 16'd300, 16'd40, 15'd1};
    run_phase(setup, 30, 1'b0);
    setup.threshold  = 12'($urandom_range(0, 2200) - 1100);
    setup.tpm        = 16'($urandom_range(1, 3000));
    setup.high_limit = 16'($urandom_range(0, 800));
    setup.limit      = 15'($urandom_range(1200, 32767));
    run_phase(setup, 70, 1'b0);
    setup = '{THRESHOLD_RESET, TPM_RESET, HIGH_LIMIT_RESET, SAMPLE_LIM_RESET};
    run_phase(setup, 60, 1'b0);

    wait_results_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d sample words under %0d register settings; %0d results compared.",
             samples_sent, settings_used, reports_checked);
    $display("Among them %0d out-of-bounds samples, %0d peaks and %0d mean refreshes.",
             invalid_checked, peaks_checked, means_checked);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived.",
               mismatch_count, pending_reports.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/prd_pkg.sv
hw/rtl/prd_channels.sv
hw/rtl/prd_div.sv
hw/rtl/pulse_rate_detector.sv
tb/sv/pulse_rate_detector_test.sv
